>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file tlpq_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    `ASSERT_CLK(lbl, clk, rst_n, !(expr), msg)

`endif

>>> hw/rtl/tlpq_pkg.sv
`default_nettype none

package tlpq_pkg;

    localparam int LEVEL_DEPTH_DEF = 16;
    localparam int NUM_LEVELS      = 3;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    typedef enum logic [2:0] {
        ST_PUSHED  = 3'd0,
        ST_POPPED  = 3'd1,
        ST_INVALID = 3'd2,
        ST_EMPTY   = 3'd3,
        ST_FULL    = 3'd4
    } t_status;

    typedef struct packed {
        logic               req_type;
        logic signed [31:0] push_value;
        logic [2:0]         push_level;
    } t_req;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] pop_value;
        logic [1:0]         pop_level;
    } t_rsp;

    typedef struct packed {
        logic capture;
        logic execute;
    } t_cmd;

endpackage

`default_nettype wire

>>> hw/rtl/three_level_priority_queue.sv
`default_nettype none

// Strict priority queue with three FIFO levels, level 1 the most urgent. A request is
// accepted when start is high and busy is low; busy then stays high while the controller
// passes through S_EXEC and S_RESULT, and the single result appears on o_result with
// o_done high in S_RESULT. The next request can be accepted in the cycle after o_done, so
// the block cannot take a new request before it is through with the last one. The
// controller registers the request, executes it against the level store in S_EXEC,
// presents the registered result for one cycle and returns to idle before taking another
// request. The receiver cannot stall: each result is valid for exactly the one cycle in
// which o_done is high.
module three_level_priority_queue #(
    parameter int LEVEL_DEPTH = tlpq_pkg::LEVEL_DEPTH_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    input  wire tlpq_pkg::t_req  i_req,
    output logic                 busy,
    output logic                 o_done,
    output tlpq_pkg::t_rsp       o_result
);
    import tlpq_pkg::*;

    t_cmd cmd;

    tlpq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .o_cmd   (cmd),
        .busy    (busy),
        .o_done  (o_done)
    );

    tlpq_datapath #(
        .LEVEL_DEPTH (LEVEL_DEPTH)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_req    (i_req),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

>>> hw/rtl/tlpq_ctrl.sv
`default_nettype none

module tlpq_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output tlpq_pkg::t_cmd     o_cmd,
    output logic               busy,
    output logic               o_done
);
    import tlpq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESULT
    } t_state;

    t_state r_state;
    logic   r_busy;
    logic   r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_done <= 1'b0;
                    if (start) begin
                        r_state <= S_EXEC;
                        r_busy  <= 1'b1;
                    end
                end
                S_EXEC: begin
                    r_state <= S_RESULT;
                    r_done  <= 1'b1;
                end
                S_RESULT: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                    r_done  <= 1'b0;
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                    r_done  <= 1'b0;
                end
            endcase
        end
    end

    assign o_cmd.capture = start && (r_state == S_IDLE);
    assign o_cmd.execute = (r_state == S_EXEC);
    assign busy          = r_busy;
    assign o_done        = r_done;

endmodule

`default_nettype wire

>>> hw/rtl/tlpq_datapath.sv
`default_nettype none

module tlpq_datapath #(
    parameter int LEVEL_DEPTH = tlpq_pkg::LEVEL_DEPTH_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire tlpq_pkg::t_cmd  i_cmd,
    input  wire tlpq_pkg::t_req  i_req,
    output tlpq_pkg::t_rsp       o_result
);
    import tlpq_pkg::*;

    localparam int IW     = $clog2(LEVEL_DEPTH);
    localparam int CW     = $clog2(LEVEL_DEPTH + 1);
    localparam int SLOTS  = NUM_LEVELS * LEVEL_DEPTH;
    localparam int AW     = $clog2(SLOTS);
    localparam int BASE_1 = LEVEL_DEPTH;
    localparam int BASE_2 = 2 * LEVEL_DEPTH;

    logic signed [31:0] r_mem [SLOTS];
    logic signed [31:0] r_rd_data;
    t_req               r_req;
    t_status            r_status;
    logic [1:0]         r_plev;
    logic [IW-1:0]      r_head [NUM_LEVELS];
    logic [IW-1:0]      r_tail [NUM_LEVELS];
    logic [CW-1:0]      r_fill [NUM_LEVELS];

    t_status       n_status;
    logic [1:0]    n_plev;
    logic [1:0]    q;
    logic          do_push;
    logic          do_pop;
    logic [IW-1:0] slot;
    logic [IW-1:0] slot_next;
    logic [AW-1:0] addr;

    always_comb begin
        n_status = ST_EMPTY;
        n_plev   = 2'd0;
        q        = 2'd0;
        do_push  = 1'b0;
        do_pop   = 1'b0;
        if (r_req.req_type == REQ_PUSH) begin
            if (r_req.push_level inside {[3'd1:3'd3]}) begin
                q = 2'(r_req.push_level - 3'd1);
                if (r_fill[q] == CW'(LEVEL_DEPTH)) begin
                    n_status = ST_FULL;
                end else begin
                    n_status = ST_PUSHED;
                    do_push  = 1'b1;
                end
            end else begin
                n_status = ST_INVALID;
            end
        end else begin
            if (r_fill[0] != '0) begin
                q      = 2'd0;
                do_pop = 1'b1;
            end else if (r_fill[1] != '0) begin
                q      = 2'd1;
                do_pop = 1'b1;
            end else if (r_fill[2] != '0) begin
                q      = 2'd2;
                do_pop = 1'b1;
            end
            if (do_pop) begin
                n_status = ST_POPPED;
                n_plev   = q + 2'd1;
            end
        end
    end

    always_comb begin
        slot      = do_push ? r_tail[q] : r_head[q];
        slot_next = (slot == IW'(LEVEL_DEPTH - 1)) ? '0 : slot + IW'(1);
        case (q)
            2'd1:    addr = AW'(BASE_1) + AW'(slot);
            2'd2:    addr = AW'(BASE_2) + AW'(slot);
            default: addr = AW'(slot);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req;
        end
        if (i_cmd.execute) begin
            r_status <= n_status;
            r_plev   <= n_plev;
        end
        if (i_cmd.execute && do_push) begin
            r_mem[addr] <= r_req.push_value;
        end
        if (i_cmd.execute && do_pop) begin
            r_rd_data <= r_mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_LEVELS; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
                r_fill[i] <= '0;
            end
        end else if (i_cmd.execute) begin
            if (do_push) begin
                r_tail[q] <= slot_next;
                r_fill[q] <= r_fill[q] + CW'(1);
            end else if (do_pop) begin
                r_head[q] <= slot_next;
                r_fill[q] <= r_fill[q] - CW'(1);
            end
        end
    end

    assign o_result.status    = r_status;
    assign o_result.pop_value = (r_status == ST_POPPED) ? r_rd_data : '0;
    assign o_result.pop_level = r_plev;

endmodule

`default_nettype wire

>>> hw/rtl/tlpq_checker.sv
`default_nettype none

`include "assert_macros.svh"

module tlpq_checker (
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            start,
    input wire tlpq_pkg::t_req  i_req,
    input wire logic            busy,
    input wire logic            o_done,
    input wire tlpq_pkg::t_rsp  o_result
);
    import tlpq_pkg::*;

    `ASSERT_CLK(a_accept_busy, i_clk, i_rst_n, start && !busy |=> busy, "busy not raised after accept")
    `ASSERT_CLK(a_accept_done, i_clk, i_rst_n, start && !busy |-> ##2 o_done, "result missing")
    `ASSERT_NEVER(a_done_idle, i_clk, i_rst_n, o_done && !busy, "result beat while idle")
    `ASSERT_CLK(a_done_pulse, i_clk, i_rst_n, o_done |=> !o_done, "result beat repeated")
    `ASSERT_NEVER(a_nopop_zero, i_clk, i_rst_n, o_done && o_result.status != ST_POPPED && (o_result.pop_value != 32'sd0 || o_result.pop_level != 2'd0), "payload not cleared")

endmodule

bind three_level_priority_queue tlpq_checker u_tlpq_checker (.*);

`default_nettype wire

>>> sim/chk_three_level_priority_queue.sv
`timescale 1ns / 1ps

module chk_three_level_priority_queue
    import tlpq_pkg::*;
#(
    parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic i_busy,
    input  t_req i_req,
    input  logic i_done,
    input  t_rsp i_result,
    output int   o_outstanding,
    output int   o_fail_count
);

    logic signed [31:0] level_words [NUM_LEVELS][LEVEL_DEPTH];
    int                 head_slot   [NUM_LEVELS];
    int                 tail_slot   [NUM_LEVELS];
    int                 word_count  [NUM_LEVELS];
    t_rsp               awaited_rsp [$];

    function automatic t_rsp serve_request(input t_req r);
        t_rsp rsp;
        int   q;
        bit   found;
        rsp.status    = ST_EMPTY;
        rsp.pop_value = '0;
        rsp.pop_level = '0;
        found         = 1'b0;
        if (r.req_type == REQ_PUSH) begin
            if (r.push_level < 1 || r.push_level > NUM_LEVELS) begin
                rsp.status = ST_INVALID;
            end else begin
                q = int'(r.push_level) - 1;
                if (word_count[q] >= LEVEL_DEPTH) begin
                    rsp.status = ST_FULL;
                end else begin
                    level_words[q][tail_slot[q]] = r.push_value;
                    tail_slot[q]  = (tail_slot[q] + 1) % LEVEL_DEPTH;
                    word_count[q] = word_count[q] + 1;
                    rsp.status    = ST_PUSHED;
                end
            end
        end else begin
            for (q = 0; q < NUM_LEVELS; q++) begin
                if (!found && word_count[q] != 0) begin
                    found         = 1'b1;
                    rsp.pop_value = level_words[q][head_slot[q]];
                    rsp.pop_level = 2'(q + 1);
                    rsp.status    = ST_POPPED;
                    head_slot[q]  = (head_slot[q] + 1) % LEVEL_DEPTH;
                    word_count[q] = word_count[q] - 1;
                end
            end
        end
        return rsp;
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        int   errs;
        errs = 0;
        if (!i_rst_n) begin
            for (int q = 0; q < NUM_LEVELS; q++) begin
                head_slot[q]  = 0;
                tail_slot[q]  = 0;
                word_count[q] = 0;
            end
            awaited_rsp.delete();
            o_outstanding <= 0;
            o_fail_count  <= 0;
        end else begin
            if (i_done) begin
                if (awaited_rsp.size() == 0) begin
                    $error("Result beat with no request outstanding: status %0d",
                           i_result.status);
                    errs++;
                end else begin
                    want = awaited_rsp.pop_front();
                    if (i_result.status !== want.status) begin
                        $error("status: expected %0d, actual %0d",
                               want.status, i_result.status);
                        errs++;
                    end
                    if (i_result.pop_value !== want.pop_value) begin
                        $error("pop_value: expected %0d, actual %0d",
                               want.pop_value, i_result.pop_value);
                        errs++;
                    end
                    if (i_result.pop_level !== want.pop_level) begin
                        $error("pop_level: expected %0d, actual %0d",
                               want.pop_level, i_result.pop_level);
                        errs++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                awaited_rsp.push_back(serve_request(i_req));
            end
            o_outstanding <= awaited_rsp.size();
            o_fail_count  <= o_fail_count + errs;
        end
    end

endmodule

>>> sim/tb_three_level_priority_queue.sv
`timescale 1ns / 1ps

module tb_three_level_priority_queue;
    import tlpq_pkg::*;

    localparam int DEPTH        = LEVEL_DEPTH_DEF;
    localparam int RANDOM_ITEMS = 1800;
    localparam int CYCLE_LIMIT  = 400000;

    logic i_clk;
    logic i_rst_n;
    logic start;
    t_req i_req;
    logic busy;
    logic o_done;
    t_rsp o_result;
    int   outstanding;
    int   fail_count;
    int   cycles = 0;

    three_level_priority_queue #(
        .LEVEL_DEPTH(DEPTH)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_done  (o_done),
        .o_result(o_result)
    );

    chk_three_level_priority_queue #(
        .LEVEL_DEPTH(DEPTH)
    ) checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_req        (i_req),
        .i_done       (o_done),
        .i_result     (o_result),
        .o_outstanding(outstanding),
        .o_fail_count (fail_count)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic t_req make_req(input logic kind, input logic [31:0] value,
                                      input logic [2:0] level);
        t_req r;
        r.req_type   = kind;
        r.push_value = value;
        r.push_level = level;
        return r;
    endfunction

    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        case ($urandom_range(0, 7))
            0:       v = 32'h8000_0000;
            1:       v = 32'h7fff_ffff;
            2:       v = 32'h0000_0000;
            3:       v = 32'hffff_ffff;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Holds the beat on the bus until it is taken; start stays high afterward.
    task automatic issue(input t_req r, input int gap);
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
    endtask

    initial begin
        t_req        r;
        t_req        directed [$];
        int          sent;
        int          phase_len;
        int          push_pct;
        int          fav_level;
        bit          no_idle;
        logic [2:0]  lvl;
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_req   = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        directed.push_back(make_req(REQ_POP, $urandom, 3'($urandom)));
        directed.push_back(make_req(REQ_PUSH, 32'h1234_5678, 3'd0));
        directed.push_back(make_req(REQ_PUSH, 32'h8000_0000, 3'd4));
        directed.push_back(make_req(REQ_PUSH, 32'h7fff_ffff, 3'd5));
        directed.push_back(make_req(REQ_PUSH, 32'hffff_ffff, 3'd6));
        directed.push_back(make_req(REQ_PUSH, 32'h0000_0000, 3'd7));
        directed.push_back(make_req(REQ_PUSH, 32'h7fff_ffff, 3'd3));
        directed.push_back(make_req(REQ_PUSH, 32'h8000_0000, 3'd2));
        directed.push_back(make_req(REQ_PUSH, 32'h0000_0000, 3'd1));
        directed.push_back(make_req(REQ_PUSH, 32'hffff_ffff, 3'd1));
        directed.push_back(make_req(REQ_PUSH, 32'ha5a5_a5a5, 3'd3));
        directed.push_back(make_req(REQ_PUSH, 32'h5a5a_5a5a, 3'd2));
        repeat (6) directed.push_back(make_req(REQ_POP, $urandom, 3'($urandom)));
        directed.push_back(make_req(REQ_POP, 32'hffff_ffff, 3'd7));
        foreach (directed[i]) issue(directed[i], $urandom_range(0, 2));
        wait_drained();

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            phase_len = $urandom_range(20, 80);
            case ($urandom_range(0, 4))
                0:       push_pct = 100;
                1:       push_pct = 85;
                2:       push_pct = 50;
                3:       push_pct = 15;
                default: push_pct = 0;
            endcase
            fav_level = $urandom_range(1, 3);
            no_idle   = ($urandom_range(0, 3) == 0);
            repeat (phase_len) begin
                if ($urandom_range(0, 99) < push_pct) begin
                    if ($urandom_range(0, 99) < 12) begin
                        lvl = ($urandom_range(0, 4) == 0) ? 3'd0 : 3'($urandom_range(4, 7));
                    end else if ($urandom_range(0, 99) < 60) begin
                        lvl = 3'(fav_level);
                    end else begin
                        lvl = 3'($urandom_range(1, 3));
                    end
                    r = make_req(REQ_PUSH, pick_value(), lvl);
                end else begin
                    r = make_req(REQ_POP, $urandom, 3'($urandom));
                end
                issue(r, no_idle ? 0 : $urandom_range(0, 9));
                sent++;
            end
            if ($urandom_range(0, 5) == 0) wait_drained();
        end

        wait_drained();
        repeat (8) @(negedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
